/* design/qibrs_pkg.sv */
// Package for the queued I2C burst-read sequencer.
// Holds queue sizing, operation, command and phase codes, the request record and the slot helper.
// Used by the top level, which also sizes the request queue RAM instance from it.
package qibrs_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int MAX_BURST   = 256;
    localparam int CNT_W       = 9;
    localparam int IDX_W       = 9;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DATA    = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_SEND_START = 3'd1,
        CMD_RX_START   = 3'd2,
        CMD_RX_CONT    = 3'd3,
        CMD_RX_FINISH  = 3'd4,
        CMD_RX_SINGLE  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        PH_SEND_REG = 2'b01,
        PH_READING  = 2'b10
    } t_phase;

    typedef struct packed {
        logic [6:0]       dev;
        logic [7:0]       reg_addr;
        logic [15:0]      dest;
        logic [CNT_W-1:0] count;
    } t_req;

    localparam int REQ_W = $bits(t_req);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

endpackage

/* design/qibrs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters; no package dependency.
module qibrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/queued_i2c_burst_read_sequencer.sv */
// Queued I2C burst-read sequencer: ring queue of read requests and the bus command sequence.
// Each accepted input beat gives one result beat, held in one register and shown in the next cycle.
// Throughput: one beat per cycle unless the output stalls; queue and state update in one pass.
// Queue head comes from a registered-read RAM prefetched at the next read pointer, with bypass.
// Reset (synchronous, active low) clears pointers, active flag, phase, index and result valid.
// Depends on qibrs_pkg and qibrs_ram.
module queued_i2c_burst_read_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [6:0]  i_dev_address,
    input  logic [7:0]  i_reg_address,
    input  logic [15:0] i_dest_base,
    input  logic [8:0]  i_byte_count,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_cmd,
    output logic [6:0]  o_cmd_address,
    output logic        o_cmd_read,
    output logic [7:0]  o_cmd_reg,
    output logic        o_store_valid,
    output logic [15:0] o_store_addr,
    output logic [7:0]  o_store_byte,
    output logic        o_done_res,
    output logic        o_rejected,
    output logic        o_busy_res
);

    logic [qibrs_pkg::PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [qibrs_pkg::PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic                        r_active, n_active;
    qibrs_pkg::t_phase           r_phase, n_phase;
    logic [qibrs_pkg::IDX_W-1:0] r_idx, n_idx;
    qibrs_pkg::t_req             r_cur, n_cur;
    logic                        r_byp_valid;
    qibrs_pkg::t_req             r_byp_data;

    logic                        r_out_valid;
    qibrs_pkg::t_cmd             r_cmd, n_cmd;
    logic [6:0]                  r_cmd_address, n_cmd_address;
    logic                        r_cmd_read, n_cmd_read;
    logic [7:0]                  r_cmd_reg, n_cmd_reg;
    logic                        r_store_valid, n_store_valid;
    logic [15:0]                 r_store_addr, n_store_addr;
    logic [7:0]                  r_store_byte, n_store_byte;
    logic                        r_done_res, n_done_res;
    logic                        r_rejected, n_rejected;
    logic                        r_busy_res;

    logic                        acc;
    qibrs_pkg::t_op              op;
    logic                        q_empty;
    logic                        q_full;
    qibrs_pkg::t_req             in_req;
    qibrs_pkg::t_req             head;
    logic [qibrs_pkg::REQ_W-1:0] ram_q;
    qibrs_pkg::t_req             pop_src;
    logic                        pop_req;
    logic                        we;
    logic [qibrs_pkg::PTR_W-1:0] raddr;
    logic [qibrs_pkg::CNT_W-1:0] clamp_cnt;
    logic [qibrs_pkg::IDX_W-1:0] idx_inc;

    assign o_stall = r_out_valid & i_stall;
    assign acc     = i_valid & ~o_stall;
    assign op      = qibrs_pkg::t_op'(i_op);
    assign q_empty = (r_wr_ptr == r_rd_ptr);
    assign q_full  = (qibrs_pkg::next_slot(r_wr_ptr) == r_rd_ptr);
    assign in_req  = '{dev: i_dev_address, reg_addr: i_reg_address,
                       dest: i_dest_base, count: i_byte_count};
    assign head    = r_byp_valid ? r_byp_data : qibrs_pkg::t_req'(ram_q);
    assign we      = i_rst_n & acc & (op == qibrs_pkg::OP_ENQUEUE) & ~q_full;
    assign raddr   = i_rst_n ? n_rd_ptr : '0;
    assign idx_inc = r_idx + qibrs_pkg::IDX_W'(1);

    qibrs_ram #(
        .WIDTH (qibrs_pkg::REQ_W),
        .DEPTH (qibrs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wr_ptr),
        .i_wdata (in_req),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        if (pop_src.count == '0) begin
            clamp_cnt = qibrs_pkg::CNT_W'(1);
        end else if (pop_src.count > qibrs_pkg::CNT_W'(qibrs_pkg::MAX_BURST)) begin
            clamp_cnt = qibrs_pkg::CNT_W'(qibrs_pkg::MAX_BURST);
        end else begin
            clamp_cnt = pop_src.count;
        end
    end

    always_comb begin
        n_wr_ptr      = r_wr_ptr;
        n_rd_ptr      = r_rd_ptr;
        n_active      = r_active;
        n_phase       = r_phase;
        n_idx         = r_idx;
        n_cur         = r_cur;
        n_cmd         = qibrs_pkg::CMD_NONE;
        n_cmd_address = '0;
        n_cmd_read    = 1'b0;
        n_cmd_reg     = '0;
        n_store_valid = 1'b0;
        n_store_addr  = '0;
        n_store_byte  = '0;
        n_done_res    = 1'b0;
        n_rejected    = 1'b0;
        pop_req       = 1'b0;
        pop_src       = head;
        if (acc) begin
            unique case (op)
                qibrs_pkg::OP_ENQUEUE: begin
                    if (q_full) begin
                        n_rejected = 1'b1;
                    end else begin
                        n_wr_ptr = qibrs_pkg::next_slot(r_wr_ptr);
                        pop_req  = ~r_active;
                        pop_src  = q_empty ? in_req : head;
                    end
                end
                qibrs_pkg::OP_DATA: begin
                    if (r_active) begin
                        unique case (r_phase)
                            qibrs_pkg::PH_SEND_REG: begin
                                n_cmd         = (r_cur.count == qibrs_pkg::CNT_W'(1))
                                              ? qibrs_pkg::CMD_RX_SINGLE
                                              : qibrs_pkg::CMD_RX_START;
                                n_cmd_address = r_cur.dev;
                                n_cmd_read    = 1'b1;
                                n_idx         = '0;
                                n_phase       = qibrs_pkg::PH_READING;
                            end
                            qibrs_pkg::PH_READING: begin
                                n_store_valid = 1'b1;
                                n_store_addr  = r_cur.dest + 16'(r_idx);
                                n_store_byte  = i_rx_byte;
                                n_idx         = idx_inc;
                                if (idx_inc == r_cur.count - qibrs_pkg::CNT_W'(1)) begin
                                    n_cmd         = qibrs_pkg::CMD_RX_FINISH;
                                    n_cmd_address = r_cur.dev;
                                    n_cmd_read    = 1'b1;
                                end else if (idx_inc >= r_cur.count) begin
                                    n_done_res = 1'b1;
                                    n_active   = 1'b0;
                                    n_phase    = qibrs_pkg::PH_SEND_REG;
                                    pop_req    = ~q_empty;
                                end else begin
                                    n_cmd         = qibrs_pkg::CMD_RX_CONT;
                                    n_cmd_address = r_cur.dev;
                                    n_cmd_read    = 1'b1;
                                end
                            end
                            default: begin
                                n_phase = qibrs_pkg::PH_SEND_REG;
                            end
                        endcase
                    end
                end
                qibrs_pkg::OP_TIMEOUT: begin
                    n_active = 1'b0;
                end
                qibrs_pkg::OP_RESTART: begin
                    n_active = 1'b0;
                    pop_req  = ~q_empty;
                end
                default: begin
                    n_active = r_active;
                end
            endcase
        end
        if (pop_req) begin
            n_cur         = pop_src;
            n_cur.count   = clamp_cnt;
            n_rd_ptr      = qibrs_pkg::next_slot(r_rd_ptr);
            n_active      = 1'b1;
            n_phase       = qibrs_pkg::PH_SEND_REG;
            n_idx         = '0;
            n_cmd         = qibrs_pkg::CMD_SEND_START;
            n_cmd_address = pop_src.dev;
            n_cmd_read    = 1'b0;
            n_cmd_reg     = pop_src.reg_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_active    <= 1'b0;
            r_phase     <= qibrs_pkg::PH_SEND_REG;
            r_idx       <= '0;
            r_cur       <= '0;
            r_byp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_active    <= n_active;
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_cur       <= n_cur;
            r_byp_valid <= we & (r_wr_ptr == n_rd_ptr);
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= in_req;
        if (acc) begin
            r_cmd         <= n_cmd;
            r_cmd_address <= n_cmd_address;
            r_cmd_read    <= n_cmd_read;
            r_cmd_reg     <= n_cmd_reg;
            r_store_valid <= n_store_valid;
            r_store_addr  <= n_store_addr;
            r_store_byte  <= n_store_byte;
            r_done_res    <= n_done_res;
            r_rejected    <= n_rejected;
            r_busy_res    <= n_active;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_cmd         = r_cmd;
    assign o_cmd_address = r_cmd_address;
    assign o_cmd_read    = r_cmd_read;
    assign o_cmd_reg     = r_cmd_reg;
    assign o_store_valid = r_store_valid;
    assign o_store_addr  = r_store_addr;
    assign o_store_byte  = r_store_byte;
    assign o_done_res    = r_done_res;
    assign o_rejected    = r_rejected;
    assign o_busy_res    = r_busy_res;

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && op == qibrs_pkg::OP_ENQUEUE && q_full |=> o_valid && o_rejected)
        else $error("full queue enqueue not rejected");

    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> o_cmd == qibrs_pkg::CMD_NONE && !o_store_valid && !o_done_res)
        else $error("rejected beat carries a command or store");

    a_done_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> o_store_valid)
        else $error("done without the last byte stored");

    a_timeout_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && op == qibrs_pkg::OP_TIMEOUT |=> !r_active && !o_busy_res)
        else $error("timeout left a request active");

    a_read_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cmd_read |->
            o_cmd != qibrs_pkg::CMD_NONE && o_cmd != qibrs_pkg::CMD_SEND_START)
        else $error("read direction on a non-receive command");

endmodule
